[rtl/mbx_pkg.sv]
// Shared types and codes for the host-side mailbox.
package mbx_pkg;

  localparam int FIFO_DEPTH_DEF = 24;

  // Item kinds
  localparam logic [2:0] KIND_HOST_READ  = 3'd0;
  localparam logic [2:0] KIND_HOST_WRITE = 3'd1;
  localparam logic [2:0] KIND_HOST_PEEK  = 3'd2;
  localparam logic [2:0] KIND_PARA_PUSH  = 3'd3;
  localparam logic [2:0] KIND_PARA_TAKE  = 3'd4;

  // Host register offsets
  localparam logic [2:0] OFF_R1_STAT = 3'd0;
  localparam logic [2:0] OFF_R1_DATA = 3'd1;
  localparam logic [2:0] OFF_R2_STAT = 3'd2;
  localparam logic [2:0] OFF_R2_DATA = 3'd3;
  localparam logic [2:0] OFF_R3_STAT = 3'd4;
  localparam logic [2:0] OFF_R3_DATA = 3'd5;
  localparam logic [2:0] OFF_R4_STAT = 3'd6;
  localparam logic [2:0] OFF_R4_DATA = 3'd7;

  // Parasite channel numbers
  localparam logic [1:0] CH_R1 = 2'd0;
  localparam logic [1:0] CH_R2 = 2'd1;
  localparam logic [1:0] CH_R3 = 2'd2;
  localparam logic [1:0] CH_R4 = 2'd3;

  // Control write and flag bit positions
  localparam int CTL_S_BIT  = 7;
  localparam int CTL_T_BIT  = 6;
  localparam int FLAG_V_BIT = 4;
  localparam int FLAG_Q_BIT = 0;
  localparam logic [5:0] FLAG_ONES = 6'h3F;

  // R1 parasite-to-host FIFO command and status
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

[rtl/mbx_p2h_fifo.sv]
// R1 parasite-to-host byte FIFO: memory, pointers and head prefetch.
module mbx_p2h_fifo #(
  parameter int DEPTH = mbx_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mbx_pkg::fifo_cmd_t    cmd,
  input  logic [7:0]            wdata,
  output mbx_pkg::fifo_stat_t   stat,
  output logic [7:0]            head_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [7:0]    rd_q;

  assign tail_sum = SW'(head) + SW'(count);
  assign tail = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  always_comb begin
    head_next  = head;
    count_next = count;
    if (cmd.clear) begin
      head_next  = '0;
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      head_next  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Keep the head entry prefetched; forward a write that lands on it.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= wdata;
    end
    if (cmd.push && (tail == head_next)) begin
      rd_q <= wdata;
    end else begin
      rd_q <= mem[head_next];
    end
  end

  assign head_data  = rd_q;
  assign stat.empty = (count == '0);
  assign stat.full  = (count >= CW'(DEPTH));

endmodule

[rtl/mbx_chan.sv]
// Latches, R3 two-byte buffers, control flags and result decode.
module mbx_chan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [2:0]           kind,
  input  logic [2:0]           host_offset,
  input  logic [1:0]           channel,
  input  logic [7:0]           data_in,
  input  mbx_pkg::fifo_stat_t  fifo_stat,
  input  logic [7:0]           fifo_head_data,
  output mbx_pkg::fifo_cmd_t   fifo_cmd,
  output logic [7:0]           read_data,
  output logic                 stalled,
  output logic                 host_irq
);

  localparam int H2P_R1 = 0;
  localparam int H2P_R2 = 1;
  localparam int H2P_R4 = 2;
  localparam int P2H_R2 = 0;
  localparam int P2H_R4 = 1;

  logic [5:0] ctrl, ctrl_next;
  logic [7:0] h2p_val [3];
  logic [7:0] h2p_val_next [3];
  logic [2:0] h2p_full, h2p_full_next;
  logic [7:0] p2h_val [2];
  logic [7:0] p2h_val_next [2];
  logic [1:0] p2h_full, p2h_full_next;
  logic [7:0] ph_store [2];
  logic [7:0] ph_store_next [2];
  logic       ph_head, ph_head_next, ph_tail, ph_tail_next;
  logic [1:0] ph_cnt, ph_cnt_next;
  logic [7:0] pp_store [2];
  logic [7:0] pp_store_next [2];
  logic       pp_head, pp_head_next, pp_tail, pp_tail_next;
  logic [1:0] pp_cnt, pp_cnt_next;
  logic [1:0] thr;
  logic [7:0] status;
  logic       consume;

  assign thr = ctrl[mbx_pkg::FLAG_V_BIT] ? 2'd2 : 2'd1;

  always_comb begin
    unique case (host_offset)
      mbx_pkg::OFF_R1_STAT: status = {!fifo_stat.empty, !h2p_full[H2P_R1], ctrl};
      mbx_pkg::OFF_R2_STAT: status = {p2h_full[P2H_R2], !h2p_full[H2P_R2],
                                      mbx_pkg::FLAG_ONES};
      mbx_pkg::OFF_R3_STAT: status = {pp_cnt >= thr, ph_cnt < thr, mbx_pkg::FLAG_ONES};
      default:              status = {p2h_full[P2H_R4], !h2p_full[H2P_R4],
                                      mbx_pkg::FLAG_ONES};
    endcase
  end

  always_comb begin
    ctrl_next     = ctrl;
    h2p_val_next  = h2p_val;
    h2p_full_next = h2p_full;
    p2h_val_next  = p2h_val;
    p2h_full_next = p2h_full;
    ph_store_next = ph_store;
    ph_head_next  = ph_head;
    ph_tail_next  = ph_tail;
    ph_cnt_next   = ph_cnt;
    pp_store_next = pp_store;
    pp_head_next  = pp_head;
    pp_tail_next  = pp_tail;
    pp_cnt_next   = pp_cnt;
    fifo_cmd      = '0;
    read_data     = 8'd0;
    stalled       = 1'b0;
    consume       = (kind == mbx_pkg::KIND_HOST_READ);

    unique case (kind)
      mbx_pkg::KIND_HOST_READ, mbx_pkg::KIND_HOST_PEEK: begin
        unique case (host_offset)
          mbx_pkg::OFF_R1_DATA: begin
            if (!fifo_stat.empty) begin
              read_data    = fifo_head_data;
              fifo_cmd.pop = consume;
            end
          end
          mbx_pkg::OFF_R2_DATA: begin
            read_data = p2h_val[P2H_R2];
            if (consume) p2h_full_next[P2H_R2] = 1'b0;
          end
          mbx_pkg::OFF_R3_DATA: begin
            if (pp_cnt != 2'd0) begin
              read_data = pp_store[pp_head];
              if (consume) begin
                pp_head_next = !pp_head;
                pp_cnt_next  = pp_cnt - 2'd1;
              end
            end
          end
          mbx_pkg::OFF_R4_DATA: begin
            read_data = p2h_val[P2H_R4];
            if (consume) p2h_full_next[P2H_R4] = 1'b0;
          end
          default: read_data = status;
        endcase
      end
      mbx_pkg::KIND_HOST_WRITE: begin
        unique case (host_offset)
          mbx_pkg::OFF_R1_STAT: begin
            if (data_in[mbx_pkg::CTL_S_BIT]) begin
              // Soft reset: empty every channel, preload dummy R3 byte.
              if (data_in[mbx_pkg::CTL_T_BIT]) begin
                h2p_val_next   = '{default: 8'd0};
                h2p_full_next  = '0;
                p2h_val_next   = '{default: 8'd0};
                p2h_full_next  = '0;
                ph_store_next  = '{default: 8'd0};
                ph_head_next   = 1'b0;
                ph_tail_next   = 1'b0;
                ph_cnt_next    = 2'd0;
                pp_store_next  = '{default: 8'd0};
                pp_head_next   = 1'b0;
                pp_tail_next   = 1'b1;
                pp_cnt_next    = 2'd1;
                fifo_cmd.clear = 1'b1;
              end
              ctrl_next = ctrl | data_in[5:0];
            end else begin
              ctrl_next = ctrl & ~data_in[5:0];
            end
          end
          mbx_pkg::OFF_R1_DATA: begin
            if (h2p_full[H2P_R1]) begin
              stalled = 1'b1;
            end else begin
              h2p_val_next[H2P_R1]  = data_in;
              h2p_full_next[H2P_R1] = 1'b1;
            end
          end
          mbx_pkg::OFF_R2_DATA: begin
            h2p_val_next[H2P_R2]  = data_in;
            h2p_full_next[H2P_R2] = 1'b1;
          end
          mbx_pkg::OFF_R3_DATA: begin
            if (ph_cnt >= 2'd2) begin
              stalled = 1'b1;
            end else begin
              ph_store_next[ph_tail] = data_in;
              ph_tail_next = !ph_tail;
              ph_cnt_next  = ph_cnt + 2'd1;
            end
          end
          mbx_pkg::OFF_R4_DATA: begin
            if (h2p_full[H2P_R4]) begin
              stalled = 1'b1;
            end else begin
              h2p_val_next[H2P_R4]  = data_in;
              h2p_full_next[H2P_R4] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      mbx_pkg::KIND_PARA_PUSH: begin
        unique case (channel)
          mbx_pkg::CH_R1: begin
            if (fifo_stat.full) stalled = 1'b1;
            else fifo_cmd.push = 1'b1;
          end
          mbx_pkg::CH_R2: begin
            if (p2h_full[P2H_R2]) begin
              stalled = 1'b1;
            end else begin
              p2h_val_next[P2H_R2]  = data_in;
              p2h_full_next[P2H_R2] = 1'b1;
            end
          end
          mbx_pkg::CH_R3: begin
            if (pp_cnt >= 2'd2) begin
              stalled = 1'b1;
            end else begin
              pp_store_next[pp_tail] = data_in;
              pp_tail_next = !pp_tail;
              pp_cnt_next  = pp_cnt + 2'd1;
            end
          end
          default: begin
            if (p2h_full[P2H_R4]) begin
              stalled = 1'b1;
            end else begin
              p2h_val_next[P2H_R4]  = data_in;
              p2h_full_next[P2H_R4] = 1'b1;
            end
          end
        endcase
      end
      mbx_pkg::KIND_PARA_TAKE: begin
        unique case (channel)
          mbx_pkg::CH_R1: begin
            if (h2p_full[H2P_R1]) begin
              read_data = h2p_val[H2P_R1];
              h2p_full_next[H2P_R1] = 1'b0;
            end
          end
          mbx_pkg::CH_R2: begin
            if (h2p_full[H2P_R2]) begin
              read_data = h2p_val[H2P_R2];
              h2p_full_next[H2P_R2] = 1'b0;
            end
          end
          mbx_pkg::CH_R3: begin
            if (ph_cnt != 2'd0) begin
              read_data    = ph_store[ph_head];
              ph_head_next = !ph_head;
              ph_cnt_next  = ph_cnt - 2'd1;
            end
          end
          default: begin
            if (h2p_full[H2P_R4]) begin
              read_data = h2p_val[H2P_R4];
              h2p_full_next[H2P_R4] = 1'b0;
            end
          end
        endcase
      end
      default: ;
    endcase

    if (!go) fifo_cmd = '0;
    host_irq = ctrl_next[mbx_pkg::FLAG_Q_BIT] && p2h_full_next[P2H_R4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl     <= '0;
      h2p_val  <= '{default: 8'd0};
      h2p_full <= '0;
      p2h_val  <= '{default: 8'd0};
      p2h_full <= '0;
      ph_store <= '{default: 8'd0};
      ph_head  <= 1'b0;
      ph_tail  <= 1'b0;
      ph_cnt   <= 2'd0;
      pp_store <= '{default: 8'd0};
      pp_head  <= 1'b0;
      pp_tail  <= 1'b1;
      pp_cnt   <= 2'd1;
    end else if (go) begin
      ctrl     <= ctrl_next;
      h2p_val  <= h2p_val_next;
      h2p_full <= h2p_full_next;
      p2h_val  <= p2h_val_next;
      p2h_full <= p2h_full_next;
      ph_store <= ph_store_next;
      ph_head  <= ph_head_next;
      ph_tail  <= ph_tail_next;
      ph_cnt   <= ph_cnt_next;
      pp_store <= pp_store_next;
      pp_head  <= pp_head_next;
      pp_tail  <= pp_tail_next;
      pp_cnt   <= pp_cnt_next;
    end
  end

endmodule

[rtl/dual_port_mailbox_fifo_host_side.sv]
// Path: each item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the result side accepts; the state update for an item
// is one pass of logic between the input register and the result register, so items follow with no gap.
// The R1 FIFO head byte is prefetched from its memory each cycle so a read needs no extra wait.
// Reset (rst, synchronous, active high) empties all channels, clears the control flags and
// preloads one zero byte into the R3 parasite-to-host buffer; no clearing pass is needed.
module dual_port_mailbox_fifo_host_side #(
  parameter int FIFO_DEPTH = mbx_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // host_offset[2:0], channel[4:3], data_in[12:5], zero
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data[7:0], stalled[8], host_irq[9], zero
);

  // Input register
  logic       in_valid;
  logic [2:0] in_kind;
  logic [2:0] in_offset;
  logic [1:0] in_channel;
  logic [7:0] in_data;

  // Result register
  logic [7:0] out_read_data;
  logic       out_stalled;
  logic       out_irq;

  // Results of the item in the input register
  logic [7:0] res_read_data;
  logic       res_stalled;
  logic       res_irq;

  mbx_pkg::fifo_cmd_t  fifo_cmd;
  mbx_pkg::fifo_stat_t fifo_stat;
  logic [7:0]          fifo_head_data;

  logic advance;

  // Advance the held item when the result register is free or being emptied this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  // Take a new transfer whenever the input register empties or moves on.
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind    <= s_tuser;
      in_offset  <= s_tdata[2:0];
      in_channel <= s_tdata[4:3];
      in_data    <= s_tdata[12:5];
    end
  end

  mbx_p2h_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .cmd       (fifo_cmd),
    .wdata     (in_data),
    .stat      (fifo_stat),
    .head_data (fifo_head_data)
  );

  mbx_chan u_chan (
    .clk            (clk),
    .rst            (rst),
    .go             (advance),
    .kind           (in_kind),
    .host_offset    (in_offset),
    .channel        (in_channel),
    .data_in        (in_data),
    .fifo_stat      (fifo_stat),
    .fifo_head_data (fifo_head_data),
    .fifo_cmd       (fifo_cmd),
    .read_data      (res_read_data),
    .stalled        (res_stalled),
    .host_irq       (res_irq)
  );

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data <= res_read_data;
      out_stalled   <= res_stalled;
      out_irq       <= res_irq;
    end
  end

  assign m_tdata = {6'd0, out_irq, out_stalled, out_read_data};

endmodule

[rtl/mbx_checker.sv]
// Port-level checks for the host-side mailbox, bound to the top level.
module mbx_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while held");

  // Coming out of reset the block is empty and ready.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> (s_tready && !m_tvalid))
    else $error("not empty after reset");

  // A refused access never returns data.
  a_stall_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
    else $error("stalled result carries data");

  // An accepted item reaches the result register once the output side is ready.
  a_progress: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("accepted item did not advance");

  // Padding bits of the result stay zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:10] == 6'd0))
    else $error("result padding not zero");

endmodule

bind dual_port_mailbox_fifo_host_side mbx_checker u_mbx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/mailbox_checker.sv]
// Checker for the host-side mailbox: predicts each transfer's result and compares it.
module mailbox_checker
  import mbx_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // host_offset[2:0], channel[4:3], data_in[12:5], zero
  input  logic [2:0]  s_tuser,   // kind[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // read_data[7:0], stalled[8], host_irq[9], zero
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] read_data;
    logic       stalled;
    logic       host_irq;
  } mbx_result_t;

  mbx_result_t expected_results[$];
  int          errors = 0;

  // Predicted mailbox state
  logic [5:0]  flags;
  logic [7:0]  r1_bytes [DEPTH];
  int unsigned r1_head, r1_fill;
  logic [7:0]  to_para_val [3];   // R1, R2, R4 host-to-parasite latches
  logic        to_para_full [3];
  logic [7:0]  to_host_val [2];   // R2, R4 parasite-to-host latches
  logic        to_host_full [2];
  logic [7:0]  down_buf [2];      // R3 host to parasite
  logic        down_head, down_tail;
  int          down_fill;
  logic [7:0]  up_buf [2];        // R3 parasite to host
  logic        up_head, up_tail;
  int          up_fill;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Empty every channel; R3 towards the host keeps one dummy zero byte.
  task automatic clear_channels();
    for (int i = 0; i < 3; i++) begin
      to_para_val[i] = 8'h00;
      to_para_full[i] = 1'b0;
    end
    for (int i = 0; i < 2; i++) begin
      to_host_val[i] = 8'h00;
      to_host_full[i] = 1'b0;
      down_buf[i] = 8'h00;
      up_buf[i] = 8'h00;
    end
    r1_head = 0;
    r1_fill = 0;
    down_head = 1'b0;
    down_tail = 1'b0;
    down_fill = 0;
    up_head = 1'b0;
    up_tail = 1'b1;
    up_fill = 1;
  endtask

  task automatic host_fetch(input logic [2:0] off, input logic consume, output logic [7:0] v);
    int thr;
    thr = flags[FLAG_V_BIT] ? 2 : 1;
    v = 8'h00;
    case (off)
      OFF_R1_DATA: if (r1_fill > 0) begin
        v = r1_bytes[r1_head];
        if (consume) begin
          r1_head = (r1_head + 1) % DEPTH;
          r1_fill--;
        end
      end
      OFF_R2_DATA: begin
        v = to_host_val[0];
        if (consume) to_host_full[0] = 1'b0;
      end
      OFF_R3_DATA: if (up_fill > 0) begin
        v = up_buf[up_head];
        if (consume) begin
          up_head = ~up_head;
          up_fill--;
        end
      end
      OFF_R4_DATA: begin
        v = to_host_val[1];
        if (consume) to_host_full[1] = 1'b0;
      end
      // status: data available, space available, then flags or all ones
      OFF_R1_STAT: v = {r1_fill > 0, !to_para_full[0], flags};
      OFF_R2_STAT: v = {to_host_full[0], !to_para_full[1], FLAG_ONES};
      OFF_R3_STAT: v = {up_fill >= thr, down_fill < thr, FLAG_ONES};
      default:     v = {to_host_full[1], !to_para_full[2], FLAG_ONES};
    endcase
  endtask

  task automatic predict_mailbox(input logic [2:0] kind, input logic [2:0] off,
                                 input logic [1:0] ch, input logic [7:0] d,
                                 output mbx_result_t r);
    logic [7:0] v;
    logic       refused;
    int         i;
    v = 8'h00;
    refused = 1'b0;
    case (kind)
      KIND_HOST_READ: host_fetch(off, 1'b1, v);
      KIND_HOST_PEEK: host_fetch(off, 1'b0, v);
      KIND_HOST_WRITE: begin
        case (off)
          OFF_R1_STAT: if (d[CTL_S_BIT]) begin
            if (d[CTL_T_BIT]) clear_channels();
            flags |= d[5:0];
          end else begin
            flags &= ~d[5:0];
          end
          OFF_R1_DATA, OFF_R4_DATA: begin
            i = (off == OFF_R1_DATA) ? 0 : 2;
            if (to_para_full[i]) begin
              refused = 1'b1;
            end else begin
              to_para_val[i] = d;
              to_para_full[i] = 1'b1;
            end
          end
          OFF_R2_DATA: begin
            to_para_val[1] = d;
            to_para_full[1] = 1'b1;
          end
          OFF_R3_DATA: if (down_fill >= 2) begin
            refused = 1'b1;
          end else begin
            down_buf[down_tail] = d;
            down_tail = ~down_tail;
            down_fill++;
          end
          default: ;
        endcase
      end
      KIND_PARA_PUSH: begin
        case (ch)
          CH_R1: if (r1_fill >= DEPTH) begin
            refused = 1'b1;
          end else begin
            r1_bytes[(r1_head + r1_fill) % DEPTH] = d;
            r1_fill++;
          end
          CH_R3: if (up_fill >= 2) begin
            refused = 1'b1;
          end else begin
            up_buf[up_tail] = d;
            up_tail = ~up_tail;
            up_fill++;
          end
          default: begin
            i = (ch == CH_R2) ? 0 : 1;
            if (to_host_full[i]) begin
              refused = 1'b1;
            end else begin
              to_host_val[i] = d;
              to_host_full[i] = 1'b1;
            end
          end
        endcase
      end
      KIND_PARA_TAKE: begin
        if (ch == CH_R3) begin
          if (down_fill > 0) begin
            v = down_buf[down_head];
            down_head = ~down_head;
            down_fill--;
          end
        end else begin
          i = (ch == CH_R1) ? 0 : (ch == CH_R2) ? 1 : 2;
          if (to_para_full[i]) begin
            v = to_para_val[i];
            to_para_full[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.read_data = v;
    r.stalled = refused;
    r.host_irq = flags[FLAG_Q_BIT] && to_host_full[1];
  endtask

  always @(posedge clk) begin
    mbx_result_t got, want, fresh;
    if (rst) begin
      flags = '0;
      clear_channels();
      expected_results.delete();
    end else begin
      // a result leaving now belongs to an earlier transfer, so pop before pushing
      if (m_tvalid && m_tready) begin
        got.read_data = m_tdata[7:0];
        got.stalled = m_tdata[8];
        got.host_irq = m_tdata[9];
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_data %02h stalled %0b host_irq %0b",
                 got.read_data, got.stalled, got.host_irq);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, got.read_data);
            errors++;
          end
          if (got.stalled !== want.stalled) begin
            $error("stalled: expected %0b, got %0b", want.stalled, got.stalled);
            errors++;
          end
          if (got.host_irq !== want.host_irq) begin
            $error("host_irq: expected %0b, got %0b", want.host_irq, got.host_irq);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_mailbox(s_tuser, s_tdata[2:0], s_tdata[4:3], s_tdata[12:5], fresh);
        expected_results.push_back(fresh);
      end
    end
    pending <= expected_results.size();
    fail_count <= errors;
  end

endmodule

[tb/tb.sv]
// Top of the mailbox testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb;
  import mbx_pkg::*;

  localparam int ITEM_GOAL      = 1175;  // directed items plus the random run
  localparam int IDLE_PCT       = 14;    // chance in a hundred of an idle cycle, each side
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES   = 6;     // extra wait after draining, as a margin

  // Control register bytes: S bit plus flag ORs them in, S clear ANDs them out
  localparam logic [7:0] CTL_SET_Q   = 8'h81;
  localparam logic [7:0] CTL_CLR_Q   = 8'h01;
  localparam logic [7:0] CTL_SET_V   = 8'h90;
  localparam logic [7:0] CTL_CLR_V   = 8'h10;
  localparam logic [7:0] CTL_RST_ALL = 8'hFF;  // soft reset, then set every flag
  localparam logic [7:0] CTL_CLR_ALL = 8'h3F;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;   // host_offset[2:0], channel[4:3], data_in[12:5], zero
  logic [2:0]  s_tuser = '0;   // kind[2:0]
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;        // read_data[7:0], stalled[8], host_irq[9], zero

  int fail_count;
  int pending;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  logic [2:0] latch_offs [3] = '{OFF_R1_DATA, OFF_R2_DATA, OFF_R4_DATA};
  logic [1:0] latch_chs [3]  = '{CH_R1, CH_R2, CH_R4};

  dual_port_mailbox_fifo_host_side DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mailbox_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall at random unless the quiet stretch is running.
  always @(posedge clk) begin
    m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, maybe after a short idle gap, and hold it until the transfer.
  task automatic send_item(input logic [2:0] kind, input logic [2:0] off,
                           input logic [1:0] ch, input logic [7:0] d);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {3'b000, d, ch, off};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    bit         paused_once;
    logic [2:0] kind;
    logic [2:0] off;
    logic [7:0] d;
    paused_once = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    send_item(KIND_HOST_PEEK,  OFF_R3_STAT, CH_R1, 8'h00);  // dummy R3 byte shows as data
    send_item(KIND_HOST_READ,  OFF_R3_DATA, CH_R1, 8'h00);  // take the dummy byte
    send_item(KIND_HOST_READ,  OFF_R3_DATA, CH_R1, 8'h00);  // R3 now empty
    send_item(KIND_HOST_READ,  OFF_R1_DATA, CH_R1, 8'h00);  // empty FIFO reads zero
    send_item(KIND_HOST_WRITE, OFF_R1_DATA, CH_R1, 8'hFF);
    send_item(KIND_HOST_WRITE, OFF_R1_DATA, CH_R1, 8'h12);  // latch full, refused
    send_item(KIND_PARA_TAKE,  OFF_R1_STAT, CH_R1, 8'h00);
    send_item(KIND_PARA_TAKE,  OFF_R1_STAT, CH_R1, 8'h00);  // take from empty latch
    send_item(KIND_PARA_PUSH,  OFF_R1_STAT, CH_R4, 8'hA5);
    send_item(KIND_PARA_PUSH,  OFF_R1_STAT, CH_R4, 8'h5A);  // R4 latch full, refused
    send_item(KIND_HOST_WRITE, OFF_R1_STAT, CH_R1, CTL_SET_Q);  // interrupt rises
    send_item(KIND_HOST_PEEK,  OFF_R4_DATA, CH_R1, 8'h00);  // peek leaves the latch full
    send_item(KIND_HOST_READ,  OFF_R4_DATA, CH_R1, 8'h00);  // read empties it, irq drops
    send_item(KIND_HOST_READ,  OFF_R2_DATA, CH_R1, 8'h00);  // empty latch still returns value
    send_item(KIND_HOST_WRITE, OFF_R2_DATA, CH_R1, 8'h01);
    send_item(KIND_HOST_WRITE, OFF_R4_STAT, CH_R1, 8'hFF);  // status write has no effect
    send_item(KIND_HOST_WRITE, OFF_R1_STAT, CH_R1, CTL_SET_V);  // R3 threshold becomes two
    send_item(KIND_HOST_WRITE, OFF_R3_DATA, CH_R1, 8'h00);
    send_item(KIND_HOST_WRITE, OFF_R3_DATA, CH_R1, 8'h80);
    send_item(KIND_HOST_WRITE, OFF_R3_DATA, CH_R1, 8'h7F);  // two bytes held, refused
    send_item(KIND_HOST_PEEK,  OFF_R3_STAT, CH_R1, 8'h00);
    send_item(KIND_PARA_PUSH,  OFF_R1_STAT, CH_R2, 8'h3C);
    send_item(KIND_HOST_WRITE, OFF_R1_STAT, CH_R1, CTL_RST_ALL);  // soft reset then all flags
    send_item(KIND_HOST_READ,  OFF_R1_STAT, CH_R1, 8'h00);
    send_item(KIND_HOST_WRITE, OFF_R1_STAT, CH_R1, CTL_CLR_ALL);

    // Random part: mostly channel traffic in bursts, the rest noise
    while (items_sent < ITEM_GOAL) begin
      if (!paused_once && items_sent >= ITEM_GOAL / 2) begin
        wait_drained();
        paused_once = 1'b1;
      end
      // run a stretch with neither side idling
      idle_on <= !(items_sent >= 300 && items_sent < 550);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          // fill the R1 FIFO, at times to full, then drain it
          repeat ($urandom_range(1, 28)) begin
            if ($urandom_range(7) == 0)
              send_item(KIND_HOST_PEEK, 3'($urandom_range(7)), CH_R1, 8'h00);
            else
              send_item(KIND_PARA_PUSH, OFF_R1_STAT, CH_R1, 8'($urandom));
          end
          repeat ($urandom_range(1, 28)) begin
            send_item(($urandom_range(3) == 0) ? KIND_HOST_PEEK : KIND_HOST_READ,
                      ($urandom_range(3) == 0) ? OFF_R1_STAT : OFF_R1_DATA,
                      CH_R1, 8'h00);
          end
        end
        4, 5: begin
          // R3 traffic both ways with the threshold flag moving
          repeat ($urandom_range(4, 16)) begin
            case ($urandom_range(6))
              0: send_item(KIND_HOST_WRITE, OFF_R3_DATA, CH_R1, 8'($urandom));
              1: send_item(KIND_PARA_TAKE, OFF_R1_STAT, CH_R3, 8'h00);
              2: send_item(KIND_PARA_PUSH, OFF_R1_STAT, CH_R3, 8'($urandom));
              3: send_item(KIND_HOST_READ, OFF_R3_DATA, CH_R1, 8'h00);
              4: send_item(KIND_HOST_PEEK, OFF_R3_DATA, CH_R1, 8'h00);
              5: send_item(($urandom_range(1) == 0) ? KIND_HOST_READ : KIND_HOST_PEEK,
                           OFF_R3_STAT, CH_R1, 8'h00);
              default: send_item(KIND_HOST_WRITE, OFF_R1_STAT, CH_R1,
                                 ($urandom_range(1) == 0) ? CTL_SET_V : CTL_CLR_V);
            endcase
          end
        end
        6, 7: begin
          // single-byte latches and the interrupt flag
          repeat ($urandom_range(4, 12)) begin
            case ($urandom_range(7))
              0: send_item(KIND_HOST_WRITE, latch_offs[$urandom_range(2)], CH_R1,
                           8'($urandom));
              1, 7: send_item(KIND_PARA_TAKE, OFF_R1_STAT, latch_chs[$urandom_range(2)],
                              8'h00);
              2: send_item(KIND_PARA_PUSH, OFF_R1_STAT, latch_chs[$urandom_range(1, 2)],
                           8'($urandom));
              3: send_item(KIND_HOST_READ, latch_offs[$urandom_range(1, 2)], CH_R1, 8'h00);
              4: send_item(KIND_HOST_PEEK, 3'($urandom_range(7)), CH_R1, 8'h00);
              5: send_item(KIND_HOST_READ, 3'($urandom_range(3) * 2), CH_R1, 8'h00);
              default: send_item(KIND_HOST_WRITE, OFF_R1_STAT, CH_R1,
                                 ($urandom_range(1) == 0) ? CTL_SET_Q : CTL_CLR_Q);
            endcase
          end
        end
        default: begin
          // noise; thin out soft resets so the channels get a chance to fill
          repeat ($urandom_range(1, 6)) begin
            kind = 3'($urandom_range(4));
            off = 3'($urandom_range(7));
            d = 8'($urandom);
            if (kind == KIND_HOST_WRITE && off == OFF_R1_STAT && d[CTL_T_BIT] &&
                $urandom_range(3) != 0)
              d[CTL_T_BIT] = 1'b0;
            send_item(kind, off, 2'($urandom_range(3)), d);
          end
        end
      endcase
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
rtl/mbx_pkg.sv
rtl/mbx_p2h_fifo.sv
rtl/mbx_chan.sv
rtl/dual_port_mailbox_fifo_host_side.sv
rtl/mbx_checker.sv
tb/mailbox_checker.sv
tb/tb.sv
